// File: rtl/core/bwb_pkg.sv
// ----------------------------------------------------------------------------
// bwb_pkg
// Shared types, widths and codes for the Bayer white-balance scaler.
// ----------------------------------------------------------------------------
package bwb_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int LW_W      = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int PAT_W     = 3;
    localparam int LANES     = 3;

    localparam int MAX_LINE_WIDTH_DEF     = 16384;
    localparam int GAIN_FRACTION_BITS_DEF = 12;

    localparam logic [SAMPLE_W-1:0] SAT_LIMIT = 16'hFFFE;

    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAYER_PATTERN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_GAIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH    = 3'd6;

    localparam logic [PAT_W-1:0] PAT_NONE = 3'd0;
    localparam logic [PAT_W-1:0] PAT_BGGR = 3'd1;
    localparam logic [PAT_W-1:0] PAT_GRBG = 3'd2;
    localparam logic [PAT_W-1:0] PAT_GBRG = 3'd3;
    localparam logic [PAT_W-1:0] PAT_RGGB = 3'd4;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd4096;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [GAIN_W-1:0]   gain_t;
    typedef logic [PROD_W-1:0]   prod_t;

    // per-beat control that travels beside the lane products
    typedef struct packed {
        logic    gray;
        logic    bypass;
        logic    line_end;
        sample_t raw_a;
    } side_t;

endpackage

// File: rtl/core/bwb_if.sv
// ----------------------------------------------------------------------------
// bwb_in_if / bwb_out_if
// Valid/ready channels for raw pixels and scaled pixels.
// ----------------------------------------------------------------------------
interface bwb_in_if;
    import bwb_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_a;
    sample_t sample_b;
    sample_t sample_c;

    modport source (output valid, output sample_a, output sample_b, output sample_c,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                    output ready);
endinterface

interface bwb_out_if;
    import bwb_pkg::*;

    logic    valid;
    logic    ready;
    sample_t out_a;
    sample_t out_b;
    sample_t out_c;
    logic    line_end;

    modport source (output valid, output out_a, output out_b, output out_c,
                    output line_end, input ready);
    modport sink   (input valid, input out_a, input out_b, input out_c,
                    input line_end, output ready);
endinterface

// File: rtl/core/bwb_ctrl.sv
// ----------------------------------------------------------------------------
// bwb_ctrl
// Configuration registers, column/row tracking and per-lane gain selection.
// ----------------------------------------------------------------------------
module bwb_ctrl #(
    parameter int MAX_LINE_WIDTH = bwb_pkg::MAX_LINE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bwb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bwb_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           beat,
    input  bwb_pkg::sample_t               raw_a,
    input  bwb_pkg::sample_t               raw_b,
    input  bwb_pkg::sample_t               raw_c,
    output bwb_pkg::sample_t               lane_sample [bwb_pkg::LANES],
    output bwb_pkg::gain_t                 lane_gain [bwb_pkg::LANES],
    output bwb_pkg::side_t                 side
);
    import bwb_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int MW_W  = $clog2(MAX_LINE_WIDTH + 1);
    localparam int CMP_W = (MW_W > LW_W) ? MW_W : LW_W;

    logic            gray_mode_reg;
    logic [PAT_W-1:0] bayer_pattern_reg;
    logic            wide_samples_reg;
    gain_t           red_gain_reg;
    gain_t           green_gain_reg;
    gain_t           blue_gain_reg;
    logic [LW_W-1:0] line_width_reg;

    logic [COL_W-1:0] column_reg, column_next;
    logic             row_odd_reg, row_odd_next;

    logic [CMP_W-1:0] lw_ext;
    logic [CMP_W-1:0] eff_width;
    logic [CMP_W-1:0] col_plus;
    logic             last;
    logic [1:0]       pos;
    gain_t            bayer_gain;
    logic             pattern_on;
    sample_t          ld_a, ld_b, ld_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_mode_reg     <= 1'b1;
            bayer_pattern_reg <= PAT_NONE;
            wide_samples_reg  <= 1'b0;
            red_gain_reg      <= GAIN_UNITY;
            green_gain_reg    <= GAIN_UNITY;
            blue_gain_reg     <= GAIN_UNITY;
            line_width_reg    <= LW_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRAY_MODE:     gray_mode_reg     <= cfg_data[0];
                REG_BAYER_PATTERN: bayer_pattern_reg <= cfg_data[PAT_W-1:0];
                REG_WIDE_SAMPLES:  wide_samples_reg  <= cfg_data[0];
                REG_RED_GAIN:      red_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_GREEN_GAIN:    green_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_BLUE_GAIN:     blue_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_LINE_WIDTH:    line_width_reg    <= cfg_data[LW_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            row_odd_reg <= 1'b0;
        end
        else
        begin
            column_reg  <= column_next;
            row_odd_reg <= row_odd_next;
        end
    end

    always_comb
    begin
        lw_ext = CMP_W'(line_width_reg);
        if (lw_ext == '0)
            eff_width = CMP_W'(1);
        else if (lw_ext > CMP_W'(MAX_LINE_WIDTH))
            eff_width = CMP_W'(MAX_LINE_WIDTH);
        else
            eff_width = lw_ext;

        col_plus = CMP_W'(column_reg) + CMP_W'(1);
        last     = (col_plus >= eff_width);

        column_next  = column_reg;
        row_odd_next = row_odd_reg;
        if (beat)
        begin
            if (last)
            begin
                column_next  = '0;
                row_odd_next = ~row_odd_reg;
            end
            else
            begin
                column_next = col_plus[COL_W-1:0];
            end
        end
    end

    // 2x2 CFA lookup: {row parity, column parity}
    always_comb
    begin
        pos        = {row_odd_reg, column_reg[0]};
        pattern_on = 1'b1;
        bayer_gain = green_gain_reg;
        unique case (bayer_pattern_reg)
            PAT_BGGR:
                if (pos == 2'd0) bayer_gain = blue_gain_reg;
                else if (pos == 2'd3) bayer_gain = red_gain_reg;
            PAT_GRBG:
                if (pos == 2'd1) bayer_gain = red_gain_reg;
                else if (pos == 2'd2) bayer_gain = blue_gain_reg;
            PAT_GBRG:
                if (pos == 2'd1) bayer_gain = blue_gain_reg;
                else if (pos == 2'd2) bayer_gain = red_gain_reg;
            PAT_RGGB:
                if (pos == 2'd0) bayer_gain = red_gain_reg;
                else if (pos == 2'd3) bayer_gain = blue_gain_reg;
            default:
                pattern_on = 1'b0;
        endcase
    end

    always_comb
    begin
        ld_a = wide_samples_reg ? raw_a : {raw_a[7:0], 8'h00};
        ld_b = wide_samples_reg ? raw_b : {raw_b[7:0], 8'h00};
        ld_c = wide_samples_reg ? raw_c : {raw_c[7:0], 8'h00};

        lane_sample[0] = ld_a;
        lane_sample[1] = ld_b;
        lane_sample[2] = ld_c;
        lane_gain[0]   = gray_mode_reg ? bayer_gain : red_gain_reg;
        lane_gain[1]   = green_gain_reg;
        lane_gain[2]   = blue_gain_reg;

        side.gray     = gray_mode_reg;
        side.bypass   = gray_mode_reg & ~pattern_on;
        side.line_end = last;
        side.raw_a    = ld_a;
    end

endmodule

// File: rtl/core/bwb_lane.sv
// ----------------------------------------------------------------------------
// bwb_lane
// One channel multiplier: sample times gain, registered product.
// ----------------------------------------------------------------------------
module bwb_lane (
    input  logic             clk,
    input  logic             en,
    input  bwb_pkg::sample_t sample,
    input  bwb_pkg::gain_t   gain,
    output bwb_pkg::prod_t   product
);
    import bwb_pkg::*;

    prod_t product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            product_reg <= PROD_W'(sample) * PROD_W'(gain);
    end

    assign product = product_reg;

endmodule

// File: rtl/core/bwb_merge.sv
// ----------------------------------------------------------------------------
// bwb_merge
// Fixed-point rescale and clamp of the lane products, output register.
// ----------------------------------------------------------------------------
module bwb_merge #(
    parameter int GAIN_FRACTION_BITS = bwb_pkg::GAIN_FRACTION_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s1_valid,
    input  bwb_pkg::side_t   s1_side,
    input  bwb_pkg::prod_t   product [bwb_pkg::LANES],
    output logic             load_ok,
    bwb_out_if.source        pix_out
);
    import bwb_pkg::*;

    logic    valid_reg, valid_next;
    sample_t a_reg, b_reg, c_reg;
    logic    line_end_reg;
    sample_t scaled [LANES];
    prod_t   shifted [LANES];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            shifted[i] = product[i] >> GAIN_FRACTION_BITS;
            if (shifted[i] > PROD_W'(SAT_LIMIT))
                scaled[i] = SAT_LIMIT;
            else
                scaled[i] = shifted[i][SAMPLE_W-1:0];
        end
    end

    assign load_ok    = ~valid_reg | pix_out.ready;
    assign valid_next = load_ok ? s1_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && s1_valid)
        begin
            a_reg        <= s1_side.bypass ? s1_side.raw_a : scaled[0];
            b_reg        <= s1_side.gray ? '0 : scaled[1];
            c_reg        <= s1_side.gray ? '0 : scaled[2];
            line_end_reg <= s1_side.line_end;
        end
    end

    assign pix_out.valid    = valid_reg;
    assign pix_out.out_a    = a_reg;
    assign pix_out.out_b    = b_reg;
    assign pix_out.out_c    = c_reg;
    assign pix_out.line_end = line_end_reg;

endmodule

// File: rtl/core/bayer_white_balance_scaler_top.sv
// An accepted input beat is held in the lane product registers, then in the output register.
// Throughput: one pixel per cycle unless backpressure stalls; the three channel multipliers run in parallel.
// Backpressure stalls both stages; input ready follows output ready combinationally.
// Reset clears the configuration to defaults, the column/row counters and all valids.
// ----------------------------------------------------------------------------
// bayer_white_balance_scaler_top
// White-balance gain per raw pixel with Bayer CFA gain lookup in gray mode.
// ----------------------------------------------------------------------------
module bayer_white_balance_scaler_top #(
    parameter int MAX_LINE_WIDTH     = bwb_pkg::MAX_LINE_WIDTH_DEF,
    parameter int GAIN_FRACTION_BITS = bwb_pkg::GAIN_FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bwb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bwb_pkg::CFG_W-1:0]     cfg_data,
    bwb_in_if.sink                        pix_in,
    bwb_out_if.source                     pix_out
);
    import bwb_pkg::*;

    sample_t lane_sample [LANES];
    gain_t   lane_gain [LANES];
    prod_t   product [LANES];
    side_t   side;
    side_t   s1_side_reg;
    logic    s1_valid_reg, s1_valid_next;
    logic    s1_ready;
    logic    load_ok;
    logic    beat;

    assign s1_ready     = ~s1_valid_reg | load_ok;
    assign pix_in.ready = s1_ready;
    assign beat         = pix_in.valid & s1_ready;

    bwb_ctrl #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .beat       (beat),
        .raw_a      (pix_in.sample_a),
        .raw_b      (pix_in.sample_b),
        .raw_c      (pix_in.sample_c),
        .lane_sample(lane_sample),
        .lane_gain  (lane_gain),
        .side       (side)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        bwb_lane u_lane (
            .clk    (clk),
            .en     (beat),
            .sample (lane_sample[g]),
            .gain   (lane_gain[g]),
            .product(product[g])
        );
    end

    assign s1_valid_next = s1_ready ? pix_in.valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (beat)
            s1_side_reg <= side;
    end

    bwb_merge #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .s1_valid(s1_valid_reg),
        .s1_side (s1_side_reg),
        .product (product),
        .load_ok (load_ok),
        .pix_out (pix_out)
    );

endmodule

// File: verif/bwb_gain_monitor.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bwb_gain_monitor
// Follows the register port and both pixel channels of the white-balance
// scaler, computes the scaled pixel for every accepted input beat and checks
// each output beat against the oldest pixel still owed.
// ----------------------------------------------------------------------------
module bwb_gain_monitor
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bwb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bwb_pkg::CFG_W-1:0]     cfg_data,
    bwb_in_if                             pix_in,
    bwb_out_if                            pix_out,
    output int                            error_count,
    output int                            pending,
    output int                            pixels_checked,
    output int                            line_ends
);
    import bwb_pkg::*;

    typedef struct packed {
        sample_t a;
        sample_t b;
        sample_t c;
        logic    line_end;
    } scaled_pixel_t;

    scaled_pixel_t owed_pixels[$];

    logic           gray_q;
    logic [PAT_W-1:0] pattern_q;
    logic           wide_q;
    gain_t          red_q;
    gain_t          green_q;
    gain_t          blue_q;
    logic [LW_W-1:0] width_q;
    logic [13:0]    column_q;
    logic           row_odd_q;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic sample_t widen(input sample_t raw);
        return wide_q ? raw : {raw[7:0], 8'h00};
    endfunction

    function automatic sample_t apply_gain(input sample_t s, input gain_t g);
        prod_t product;
        product = prod_t'(s) * prod_t'(g);
        product = product >> GAIN_FRACTION_BITS_DEF;
        if (product > prod_t'(SAT_LIMIT))
        begin
            return SAT_LIMIT;
        end
        return product[SAMPLE_W-1:0];
    endfunction

    // 2x2 color filter lookup: {row parity, column parity}
    function automatic gain_t cfa_gain();
        logic [1:0] pos;
        pos = {row_odd_q, column_q[0]};
        case (pattern_q)
            PAT_BGGR: return (pos == 2'd0) ? blue_q : ((pos == 2'd3) ? red_q : green_q);
            PAT_GRBG: return (pos == 2'd1) ? red_q : ((pos == 2'd2) ? blue_q : green_q);
            PAT_GBRG: return (pos == 2'd1) ? blue_q : ((pos == 2'd2) ? red_q : green_q);
            default:  return (pos == 2'd0) ? red_q : ((pos == 2'd3) ? blue_q : green_q);
        endcase
    endfunction

    function automatic scaled_pixel_t scale_pixel(input sample_t a, input sample_t b,
                                                  input sample_t c);
        scaled_pixel_t px;
        int unsigned   span;
        span = 32'(width_q);
        if (span == 0)
        begin
            span = 1;
        end
        if (span > MAX_LINE_WIDTH_DEF)
        begin
            span = MAX_LINE_WIDTH_DEF;
        end
        px = '0;
        if (gray_q)
        begin
            if (pattern_q >= PAT_BGGR && pattern_q <= PAT_RGGB)
            begin
                px.a = apply_gain(widen(a), cfa_gain());
            end
            else
            begin
                px.a = widen(a);
            end
        end
        else
        begin
            px.a = apply_gain(widen(a), red_q);
            px.b = apply_gain(widen(b), green_q);
            px.c = apply_gain(widen(c), blue_q);
        end
        px.line_end = (32'(column_q) + 32'd1) >= span;
        if (px.line_end)
        begin
            column_q  = '0;
            row_odd_q = ~row_odd_q;
        end
        else
        begin
            column_q = column_q + 14'd1;
        end
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scaled_pixel_t want;
        scaled_pixel_t got;
        if (!rst_n)
        begin
            gray_q         = 1'b1;
            pattern_q      = PAT_NONE;
            wide_q         = 1'b0;
            red_q          = GAIN_UNITY;
            green_q        = GAIN_UNITY;
            blue_q         = GAIN_UNITY;
            width_q        = LW_W'(1);
            column_q       = '0;
            row_odd_q      = 1'b0;
            owed_pixels.delete();
            error_count    = 0;
            pending        = 0;
            pixels_checked = 0;
            line_ends      = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRAY_MODE:     gray_q    = cfg_data[0];
                    REG_BAYER_PATTERN: pattern_q = cfg_data[PAT_W-1:0];
                    REG_WIDE_SAMPLES:  wide_q    = cfg_data[0];
                    REG_RED_GAIN:      red_q     = cfg_data;
                    REG_GREEN_GAIN:    green_q   = cfg_data;
                    REG_BLUE_GAIN:     blue_q    = cfg_data;
                    REG_LINE_WIDTH:    width_q   = cfg_data[LW_W-1:0];
                    default: ;
                endcase
            end

            // retire before predicting so a beat can never meet its own input
            if (pix_out.valid && pix_out.ready)
            begin
                got = {pix_out.out_a, pix_out.out_b, pix_out.out_c, pix_out.line_end};
                if (owed_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("output beat %0d with no pixel owed",
                                              pixels_checked));
                end
                else
                begin
                    want = owed_pixels.pop_front();
                    if (got.a !== want.a)
                    begin
                        report_mismatch($sformatf("beat %0d out_a: expected %h, got %h",
                                                  pixels_checked, want.a, got.a));
                    end
                    if (got.b !== want.b)
                    begin
                        report_mismatch($sformatf("beat %0d out_b: expected %h, got %h",
                                                  pixels_checked, want.b, got.b));
                    end
                    if (got.c !== want.c)
                    begin
                        report_mismatch($sformatf("beat %0d out_c: expected %h, got %h",
                                                  pixels_checked, want.c, got.c));
                    end
                    if (got.line_end !== want.line_end)
                    begin
                        report_mismatch($sformatf("beat %0d line_end: expected %b, got %b",
                                                  pixels_checked, want.line_end,
                                                  got.line_end));
                    end
                end
                if (got.line_end === 1'b1)
                begin
                    line_ends++;
                end
                pixels_checked++;
            end

            if (pix_in.valid && pix_in.ready)
            begin
                owed_pixels.push_back(scale_pixel(pix_in.sample_a, pix_in.sample_b,
                                                  pix_in.sample_c));
            end
            pending = owed_pixels.size();
        end
    end

endmodule

// File: verif/bayer_white_balance_scaler_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bayer_white_balance_scaler_top_tb
// Drives raw pixels and register settings into the white-balance scaler with
// random stalls on both channels; the gain monitor predicts and checks.
// ----------------------------------------------------------------------------
module bayer_white_balance_scaler_top_tb;
    import bwb_pkg::*;

    localparam int              RANDOM_ITEMS = 750;
    localparam int              STALL_LIMIT  = 1000;
    localparam logic [PAT_W-1:0] PAT_UNUSED  = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int errors;
    int pending;
    int checked;
    int line_ends;

    bit steady      = 1'b0;
    int sent        = 0;
    int settings    = 0;
    int idle_cycles = 0;

    bwb_in_if  pix_in();
    bwb_out_if pix_out();

    bayer_white_balance_scaler_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    bwb_gain_monitor gain_monitor
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pix_in         (pix_in),
        .pix_out        (pix_out),
        .error_count    (errors),
        .pending        (pending),
        .pixels_checked (checked),
        .line_ends      (line_ends)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_out.ready <= 1'b0;
        end
        else
        begin
            pix_out.ready <= steady || ($urandom_range(99) >= 8);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (pix_in.valid && pix_in.ready)
            || (pix_out.valid && pix_out.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h00FF;
            3:       return 16'hFF00;
            default: return 16'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic gain_t rand_gain();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return GAIN_UNITY;
            3:       return 16'($urandom_range(16'hFFFF));
            default: return 16'($urandom_range(16383));
        endcase
    endfunction

    function automatic logic [LW_W-1:0] rand_width();
        case ($urandom_range(15))
            0:       return '0;
            1:       return LW_W'(MAX_LINE_WIDTH_DEF);
            2:       return LW_W'($urandom_range(32767, MAX_LINE_WIDTH_DEF + 1));
            3:       return LW_W'($urandom_range(2000, 9));
            default: return LW_W'($urandom_range(8, 1));
        endcase
    endfunction

    task automatic send_pixel(input sample_t a, input sample_t b, input sample_t c);
        bit taken;
        while (!steady && $urandom_range(99) < 8)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.sample_a <= a;
        pix_in.sample_b <= b;
        pix_in.sample_c <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = pix_in.ready;
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic send_random();
        send_pixel(rand_sample(), rand_sample(), rand_sample());
    endtask

    task automatic wait_drained();
        pix_in.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_mode(input logic gray, input logic [PAT_W-1:0] pattern,
                            input logic wide, input gain_t red, input gain_t green,
                            input gain_t blue, input logic [LW_W-1:0] width);
        wait_drained();
        write_reg(REG_GRAY_MODE, CFG_W'(gray));
        write_reg(REG_BAYER_PATTERN, CFG_W'(pattern));
        write_reg(REG_WIDE_SAMPLES, CFG_W'(wide));
        write_reg(REG_RED_GAIN, red);
        write_reg(REG_GREEN_GAIN, green);
        write_reg(REG_BLUE_GAIN, blue);
        write_reg(REG_LINE_WIDTH, CFG_W'(width));
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int target;
        int lap;
        int count;
        logic [PAT_W-1:0] pattern;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_GRAY_MODE;
        cfg_data        <= '0;
        pix_in.valid    <= 1'b0;
        pix_in.sample_a <= '0;
        pix_in.sample_b <= '0;
        pix_in.sample_c <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults: gray, unscaled, 8-bit, one pixel per line
        send_pixel(16'h00FF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFF00, 16'h0000, 16'h0000);

        // RGB with full-scale and zero gains; zero width acts as one
        set_mode(1'b0, PAT_NONE, 1'b1, 16'hFFFF, 16'h0000, GAIN_UNITY, LW_W'(0));
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h8001, 16'h7FFE, 16'h1234);

        // RGB 8-bit, pattern ignored
        set_mode(1'b0, PAT_RGGB, 1'b0, 16'h0FFF, 16'h1FFF, 16'h0001, LW_W'(2));
        send_pixel(16'hAAFF, 16'h5580, 16'h0001);
        send_pixel(16'h5500, 16'hAA7F, 16'hFFFE);

        // gray RGGB across one 2x2 tile
        set_mode(1'b1, PAT_RGGB, 1'b1, 16'h2000, 16'h1000, 16'h0800, LW_W'(2));
        repeat (4) send_pixel(16'hC001, 16'hFFFF, 16'hFFFF);

        // unused pattern code: gray passes through unlimited
        set_mode(1'b1, PAT_UNUSED, 1'b1, 16'h0000, 16'h0000, 16'h0000, LW_W'(3));
        send_pixel(16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h7FFF, 16'hFFFF, 16'hFFFF);

        // oversized width, then narrowed below the current column
        set_mode(1'b1, PAT_BGGR, 1'b0, 16'h3000, 16'h1800, 16'h0C00, LW_W'(32767));
        repeat (3) send_random();
        set_mode(1'b1, PAT_BGGR, 1'b0, 16'h3000, 16'h1800, 16'h0C00, LW_W'(2));
        repeat (2) send_random();

        target = sent + RANDOM_ITEMS;
        lap    = 0;
        while (sent < target)
        begin
            if ($urandom_range(3) == 0)
            begin
                pattern = PAT_W'($urandom_range(7));
            end
            else
            begin
                pattern = PAT_W'($urandom_range(4, 1));
            end
            set_mode(1'($urandom_range(1)), pattern, 1'($urandom_range(1)),
                     rand_gain(), rand_gain(), rand_gain(), rand_width());
            steady <= (lap == 5);
            count = (lap == 5) ? 150 : $urandom_range(50, 10);
            repeat (count) send_random();
            lap++;
        end

        wait_drained();
        steady <= 1'b0;
        repeat (8) @(posedge clk);

        $display("Sent %0d pixels under %0d register settings; %0d output beats checked,",
                 sent, settings, checked);
        $display("%0d of them closing a line.", line_ends);
        if (errors == 0 && pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
